>>> sv/ckcc_pkg.sv
// Shared types and constants for the colour-keyed column centroid block.
`default_nettype none

package ckcc_pkg;

  localparam int unsigned ColorW    = 24;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned MaskW     = 8;
  localparam int unsigned RowW      = 11;
  localparam int unsigned ColW      = 12;
  localparam int unsigned SumW      = 22;
  localparam int unsigned CntW      = 12;
  localparam int unsigned FracW     = 4;
  localparam int unsigned CentW     = 15;
  localparam int unsigned DivW      = SumW + FracW;
  localparam int unsigned DivSteps  = DivW;
  localparam int unsigned StepCntW  = $clog2(DivSteps);
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [ColorW-1:0] TargetColorRst = 24'hFF0000;
  localparam logic [ChanW-1:0]  ToleranceRst   = 8'h00;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_COLOR = 1'b0,
    REG_TOLERANCE    = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_HOLD   = 3'b100
  } ctrl_state_e;

  // Datapath to controller
  typedef struct packed {
    logic col_close;  // accepted column end with at least one hit
  } dp_status_t;

  // Controller to datapath
  typedef struct packed {
    logic busy;
    logic div_step;
    logic out_valid;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

>>> sv/color_keyed_column_centroid.sv
// Top level of the colour-keyed per-column centroid block.
// Pixels transfer at one per cycle unless stalled; a column's result comes from a serial
// divide, then waits in a held output register until it is taken.
// Pixels of the next column keep flowing during the divide; only a column end
// stalls while the previous result is still in the divider or waiting.
// Reset clears the accumulators and controller and loads the register defaults.
`default_nettype none

module color_keyed_column_centroid
  import ckcc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ColorW-1:0]  cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [ColorW-1:0]  pixel_color_i,
  input  wire logic [MaskW-1:0]   mask_level_i,
  input  wire logic [RowW-1:0]    row_i,
  input  wire logic [ColW-1:0]    column_i,
  input  wire logic               column_end_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [ColW-1:0]         out_column_o,
  output logic [CentW-1:0]        centroid_o,
  output logic [CntW-1:0]         hit_count_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_fire;

  assign in_stall_o  = column_end_i && cmd.busy;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = cmd.out_valid;

  ckcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .status_i    (status),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  ckcc_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_fire_i     (in_fire),
    .pixel_color_i (pixel_color_i),
    .mask_level_i  (mask_level_i),
    .row_i         (row_i),
    .column_i      (column_i),
    .column_end_i  (column_end_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_column_o  (out_column_o),
    .centroid_o    (centroid_o),
    .hit_count_o   (hit_count_o)
  );

  a_result_has_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_count_o != '0))
    else $error("result presented with zero hit count");

  a_close_starts_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.col_close |=> (cmd.div_step && !out_valid_o))
    else $error("column close did not start the divider");

  a_result_after_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.div_step))
    else $error("result appeared without a finished divide");

endmodule

`default_nettype wire

>>> sv/ckcc_ctrl.sv
// Controller: sequences the per-column divide and holds the result for transfer.
`default_nettype none

module ckcc_ctrl
  import ckcc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire dp_status_t status_i,
  input  wire logic       out_stall_i,
  output ctrl_cmd_t       cmd_o
);

  ctrl_state_e           state_q, state_d;
  logic [StepCntW-1:0]   step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (status_i.col_close) state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        step_d = step_q + StepCntW'(1);
        if (step_q == StepCntW'(DivSteps - 1)) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign cmd_o.busy      = (state_q != ST_IDLE);
  assign cmd_o.div_step  = (state_q == ST_DIVIDE);
  assign cmd_o.out_valid = (state_q == ST_HOLD);

endmodule

`default_nettype wire

>>> sv/ckcc_datapath.sv
// Datapath: colour match, row accumulation, serial divider and result registers.
`default_nettype none

module ckcc_datapath
  import ckcc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ColorW-1:0] cfg_wdata_i,
  input  wire logic              in_fire_i,
  input  wire logic [ColorW-1:0] pixel_color_i,
  input  wire logic [MaskW-1:0]  mask_level_i,
  input  wire logic [RowW-1:0]   row_i,
  input  wire logic [ColW-1:0]   column_i,
  input  wire logic              column_end_i,
  input  wire ctrl_cmd_t         cmd_i,
  output dp_status_t             status_o,
  output logic [ColW-1:0]        out_column_o,
  output logic [CentW-1:0]       centroid_o,
  output logic [CntW-1:0]        hit_count_o
);

  logic [ColorW-1:0] target_q;
  logic [ChanW-1:0]  tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TargetColorRst;
      tol_q    <= ToleranceRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET_COLOR: target_q <= cfg_wdata_i;
        REG_TOLERANCE:    tol_q    <= cfg_wdata_i[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // Colour match: every channel within tolerance
  logic [2:0] chan_ok;
  always_comb begin
    logic [ChanW-1:0] a, b, d;
    for (int c = 0; c < 3; c++) begin
      a = pixel_color_i[c*ChanW +: ChanW];
      b = target_q[c*ChanW +: ChanW];
      d = (a > b) ? (a - b) : (b - a);
      chan_ok[c] = (d <= tol_q);
    end
  end

  logic hit;
  assign hit = (mask_level_i != '0) && (&chan_ok);

  // Saturating accumulators
  logic [SumW-1:0] sum_q, sum_nx;
  logic [CntW-1:0] cnt_q, cnt_nx;
  logic [SumW:0]   sum_add;

  assign sum_add = {1'b0, sum_q} + (SumW+1)'(row_i);

  always_comb begin
    sum_nx = sum_q;
    cnt_nx = cnt_q;
    if (hit) begin
      sum_nx = sum_add[SumW] ? '1 : sum_add[SumW-1:0];
      if (cnt_q != '1) cnt_nx = cnt_q + CntW'(1);
    end
  end

  logic col_close;
  assign col_close = in_fire_i && column_end_i && (cnt_nx != '0);
  assign status_o.col_close = col_close;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (in_fire_i) begin
      if (column_end_i) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= sum_nx;
        cnt_q <= cnt_nx;
      end
    end
  end

  // Restoring divider, one quotient bit per cycle; quotient shifts into dq_q
  logic [DivW-1:0] dq_q;
  logic [CntW-1:0] rem_q;
  logic [CntW-1:0] divisor_q;
  logic [ColW-1:0] col_q;
  logic [CntW:0]   rem_sh;
  logic [CntW:0]   rem_sub;
  logic            ge;

  assign rem_sh  = {rem_q, dq_q[DivW-1]};
  assign ge      = (rem_sh >= {1'b0, divisor_q});
  assign rem_sub = rem_sh - {1'b0, divisor_q};

  always_ff @(posedge clk_i) begin
    if (col_close) begin
      dq_q      <= {sum_nx, FracW'(0)};
      rem_q     <= '0;
      divisor_q <= cnt_nx;
      col_q     <= column_i;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? rem_sub[CntW-1:0] : rem_sh[CntW-1:0];
      dq_q  <= {dq_q[DivW-2:0], ge};
    end
  end

  // Clamp quotients that only a saturated column can produce
  assign centroid_o   = (dq_q[DivW-1:CentW] != '0) ? '1 : dq_q[CentW-1:0];
  assign hit_count_o  = divisor_q;
  assign out_column_o = col_q;

endmodule

`default_nettype wire

>>> sim/centroid_checker.sv
// Channel monitor that predicts each column centroid and compares it with the block's output.
module centroid_checker
  import ckcc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ColorW-1:0]  cfg_wdata_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic [ColorW-1:0]  pixel_color_i,
  input  wire logic [MaskW-1:0]   mask_level_i,
  input  wire logic [RowW-1:0]    row_i,
  input  wire logic [ColW-1:0]    column_i,
  input  wire logic               column_end_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic [ColW-1:0]    out_column_i,
  input  wire logic [CentW-1:0]   centroid_i,
  input  wire logic [CntW-1:0]    hit_count_i,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o
);

  localparam int unsigned       MaxRows  = 2048;
  localparam int unsigned       MaxShown = 10;
  localparam logic [SumW-1:0]   SumMax   = '1;
  localparam logic [CntW-1:0]   CntMax   = '1;
  localparam longint unsigned   CentMax  = (64'd1 << CentW) - 1;

  typedef struct packed {
    logic [ColW-1:0]  column;
    logic [CentW-1:0] centroid;
    logic [CntW-1:0]  hits;
  } column_result_t;

  logic [ColorW-1:0] key_rgb;
  logic [ChanW-1:0]  key_tol;
  logic [SumW-1:0]   row_sum_acc;
  logic [CntW-1:0]   hits_acc;
  column_result_t    centroid_q[$];
  int unsigned       fails = 0;

  function automatic logic chan_close(logic [ChanW-1:0] a, logic [ChanW-1:0] b,
                                      logic [ChanW-1:0] tol);
    logic [ChanW-1:0] diff;
    diff = (a > b) ? a - b : b - a;
    return diff <= tol;
  endfunction

  function automatic logic pixel_matches(logic [ColorW-1:0] rgb, logic [MaskW-1:0] mask,
                                         logic [RowW-1:0] row);
    return (mask != '0) && (int'(row) < MaxRows)
        && chan_close(rgb[23:16], key_rgb[23:16], key_tol)
        && chan_close(rgb[15:8], key_rgb[15:8], key_tol)
        && chan_close(rgb[7:0], key_rgb[7:0], key_tol);
  endfunction

  task automatic note_failure(input string msg);
    fails++;
    if (fails <= MaxShown) $display("%t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    column_result_t  got;
    column_result_t  want;
    logic [SumW:0]   sum_next;
    longint unsigned quot;
    if (!rst_ni) begin
      key_rgb     = TargetColorRst;
      key_tol     = ToleranceRst;
      row_sum_acc = '0;
      hits_acc    = '0;
      centroid_q.delete();
      pending_o <= 0;
    end else begin
      // Compare the outgoing transfer first: a result never leaves in the cycle its column closes.
      if (out_valid_i && !out_stall_i) begin
        got = '{out_column_i, centroid_i, hit_count_i};
        if (centroid_q.size() == 0) begin
          note_failure($sformatf("unexpected result: column %0d centroid %0d hits %0d",
                                 got.column, got.centroid, got.hits));
        end else begin
          want = centroid_q.pop_front();
          if (got.column != want.column || got.centroid != want.centroid
              || got.hits != want.hits) begin
            note_failure($sformatf({"result mismatch: expected column %0d centroid %0d ",
                                    "hits %0d, got column %0d centroid %0d hits %0d"},
                                   want.column, want.centroid, want.hits,
                                   got.column, got.centroid, got.hits));
          end
        end
      end

      // A pixel taken at this edge still sees the key from before a write at the same edge.
      if (in_valid_i && !in_stall_i) begin
        if (pixel_matches(pixel_color_i, mask_level_i, row_i)) begin
          // Saturate rather than wrap when a column runs past its size.
          sum_next    = {1'b0, row_sum_acc} + row_i;
          row_sum_acc = (sum_next > {1'b0, SumMax}) ? SumMax : sum_next[SumW-1:0];
          if (hits_acc != CntMax) hits_acc++;
        end
        if (column_end_i) begin
          if (hits_acc != '0) begin
            quot = 64'(row_sum_acc);
            quot = (quot << FracW) / hits_acc;
            if (quot > CentMax) quot = CentMax;
            want.column   = column_i;
            want.centroid = quot[CentW-1:0];
            want.hits     = hits_acc;
            centroid_q.push_back(want);
          end
          row_sum_acc = '0;
          hits_acc    = '0;
        end
      end

      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_TARGET_COLOR: key_rgb = cfg_wdata_i;
          REG_TOLERANCE:    key_tol = cfg_wdata_i[ChanW-1:0];
          default: ;
        endcase
      end

      pending_o    <= centroid_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

>>> sim/testbench.sv
// Stimulus, handshake pacing and verdict for the colour-keyed column centroid block.
module testbench
  import ckcc_pkg::*;
();

  localparam int unsigned DrainCycles = 40;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned PhaseItems  = 120;
  localparam int unsigned LongColumn  = 100;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx   = REG_TARGET_COLOR;
  logic [ColorW-1:0]  cfg_wdata = '0;

  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [ColorW-1:0]  pixel_color = '0;
  logic [MaskW-1:0]   mask_level  = '0;
  logic [RowW-1:0]    row         = '0;
  logic [ColW-1:0]    column      = '0;
  logic               column_end  = 1'b0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ColW-1:0]    out_column;
  logic [CentW-1:0]   centroid;
  logic [CntW-1:0]    hit_count;

  int unsigned fail_count;
  int unsigned pending;

  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 83;
  int unsigned hold_req      = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned idle_cycles   = 0;
  int unsigned items_sent    = 0;

  logic [ColorW-1:0] key_rgb = TargetColorRst;
  logic [ChanW-1:0]  key_tol = ToleranceRst;
  logic [ColW-1:0]   next_col;

  always #5 clk = ~clk;

  color_keyed_column_centroid u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .pixel_color_i (pixel_color),
    .mask_level_i  (mask_level),
    .row_i         (row),
    .column_i      (column),
    .column_end_i  (column_end),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_column_o  (out_column),
    .centroid_o    (centroid),
    .hit_count_o   (hit_count)
  );

  centroid_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .pixel_color_i (pixel_color),
    .mask_level_i  (mask_level),
    .row_i         (row),
    .column_i      (column),
    .column_end_i  (column_end),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_column_i  (out_column),
    .centroid_i    (centroid),
    .hit_count_i   (hit_count),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Receiver: a requested long hold-off wins over the random stalls.
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= LongHold;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one pixel and hold it until the transfer; valid stays high on return.
  task automatic send_pixel(input logic [ColorW-1:0] rgb, input logic [MaskW-1:0] mask,
                            input logic [RowW-1:0] r, input logic [ColW-1:0] col,
                            input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_color <= rgb;
    mask_level  <= mask;
    row         <= r;
    column      <= col;
    column_end  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid, wait for every outstanding centroid, then let the divider settle.
  task automatic drain(input int unsigned settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_key(input logic [ColorW-1:0] rgb, input logic [ChanW-1:0] tol);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_TARGET_COLOR;
    cfg_wdata <= rgb;
    @(posedge clk);
    cfg_idx   <= REG_TOLERANCE;
    cfg_wdata <= {{(ColorW-ChanW){1'b0}}, tol};
    @(posedge clk);
    cfg_we  <= 1'b0;
    key_rgb = rgb;
    key_tol = tol;
  endtask

  function automatic logic [ChanW-1:0] near_channel(logic [ChanW-1:0] centre,
                                                    logic [ChanW-1:0] tol);
    int off;
    int v;
    off = $urandom_range(0, 1) ? $urandom_range(0, int'(tol)) : $urandom_range(0, int'(tol) + 2);
    v   = $urandom_range(0, 1) ? int'(centre) + off : int'(centre) - off;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[ChanW-1:0];
  endfunction

  task automatic send_column(input int unsigned len, input bit scattered);
    logic [RowW-1:0]   base;
    logic [ColorW-1:0] rgb;
    logic [MaskW-1:0]  mask;
    logic [RowW-1:0]   r;
    base = RowW'($urandom_range(0, 2047));
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 75) begin
        rgb = {near_channel(key_rgb[23:16], key_tol), near_channel(key_rgb[15:8], key_tol),
               near_channel(key_rgb[7:0], key_tol)};
      end else begin
        rgb = ColorW'($urandom_range(0, 24'hFFFFFF));
      end
      mask = ($urandom_range(0, 99) < 15) ? '0 : MaskW'($urandom_range(1, 255));
      r    = scattered ? RowW'($urandom_range(0, 2047)) : RowW'(base + i);
      send_pixel(rgb, mask, r, next_col, i == len - 1);
    end
    next_col++;
  endtask

  initial begin
    int unsigned goal;
    int unsigned len;
    next_col = ColW'($urandom_range(0, 4095));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset key: pure red, zero tolerance.
    send_pixel(24'hFF0000, 8'hFF, 11'd0, 12'd0, 1'b1);
    send_pixel(24'hFF0000, 8'h01, 11'd2047, 12'd4095, 1'b0);
    send_pixel(24'hFF0000, 8'h80, 11'd2046, 12'd4095, 1'b0);
    send_pixel(24'hFF0000, 8'h00, 11'd5, 12'd4095, 1'b0);
    send_pixel(24'hFE0000, 8'hFF, 11'd7, 12'd4095, 1'b0);
    send_pixel(24'hFF0100, 8'hFF, 11'd7, 12'd4095, 1'b0);
    send_pixel(24'hFF0001, 8'hFF, 11'd7, 12'd4095, 1'b0);
    send_pixel(24'hFF0000, 8'hFF, 11'd1000, 12'd4095, 1'b1);
    // Column with no hit: nothing comes out.
    send_pixel(24'h00FF00, 8'hFF, 11'd3, 12'd1, 1'b0);
    send_pixel(24'hFF0000, 8'h00, 11'd9, 12'd1, 1'b1);
    // Closing pixel itself misses.
    send_pixel(24'hFF0000, 8'hFF, 11'd10, 12'd2, 1'b0);
    send_pixel(24'h0000FF, 8'hFF, 11'd11, 12'd2, 1'b1);
    drain(DrainCycles);

    // Widest tolerance: any unmasked pixel counts.
    write_key(24'h000000, 8'hFF);
    send_pixel(24'hFFFFFF, 8'hFF, 11'd2047, 12'd3, 1'b0);
    send_pixel(24'h000000, 8'h01, 11'd1, 12'd3, 1'b0);
    send_pixel(24'h555555, 8'h7F, 11'd1024, 12'd3, 1'b1);

    // Long column of bottom-row hits, then check the clear.
    for (int unsigned i = 0; i < LongColumn; i++) begin
      send_pixel(ColorW'($urandom_range(0, 24'hFFFFFF)), MaskW'($urandom_range(1, 255)),
                 11'd2047, 12'd2048, i == LongColumn - 1);
    end
    send_pixel(24'hAAAAAA, 8'hFF, 11'd3, 12'd7, 1'b1);
    drain(DrainCycles);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_key(ColorW'($urandom_range(0, 24'hFFFFFF)), ChanW'($urandom_range(0, 40)));
        1: write_key(24'hFFFFFF, 8'h00);
        2: write_key(24'h000000, 8'hFF);
        3: write_key(ColorW'($urandom_range(0, 24'hFFFFFF)), ChanW'($urandom_range(0, 255)));
        4: write_key(ColorW'($urandom_range(0, 24'hFFFFFF)), 8'h01);
        default: write_key(ColorW'($urandom_range(0, 24'hFFFFFF)),
                           ChanW'($urandom_range(0, 20)));
      endcase
      if (phase == 2) begin
        send_idle_pct = 83;
        recv_idle_pct <= 27;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      // Hold the output off while short columns keep coming, so the block backs up.
      if (phase == 0) hold_req <= hold_req + 1;
      goal = items_sent + PhaseItems;
      while (items_sent < goal) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        send_column(len, $urandom_range(0, 4) == 0);
      end
      drain(DrainCycles);
    end

    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
